// ===== rtl/window_median_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the window median filter
// Shared checks that assert one property, reported through $error.
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define WINDOW_MEDIAN_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WMF_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WMF_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg
// Constants and codes shared by the window median filter modules.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int PIX_W          = 8;
  localparam int DEF_WINDOW     = 3;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int RESET_DIM      = 1024;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

endpackage

// ===== rtl/wmf_front.sv =====
// ----------------------------------------------------------------------------
// wmf_front
// Tracks input and output raster positions, writes the line store and
// gathers the window of every output that becomes ready.
// ----------------------------------------------------------------------------
`include "window_median_filter_assert.svh"

module wmf_front #(
  parameter int WINDOW     = wmf_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT,
  parameter int QDEPTH     = wmf_pkg::QUEUE_DEPTH
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [wmf_pkg::CFG_W-1:0]                cfg_data,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [wmf_pkg::PIX_W-1:0]                s_tdata,
  input  logic                                     s_tuser,
  input  logic [$clog2(QDEPTH+1)-1:0]              q_used,
  output logic                                     push,
  output logic [WINDOW*WINDOW*wmf_pkg::PIX_W-1:0]  push_data,
  output logic [WINDOW*WINDOW-1:0]                 push_mask,
  output logic                                     push_last
);

  localparam int HALF       = WINDOW / 2;
  localparam int RING       = WINDOW + 1;
  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int RW         = $clog2(MAX_HEIGHT + 1);
  localparam int BANK_DEPTH = (MAX_WIDTH + WINDOW - 1) / WINDOW;
  localparam int BAW        = $clog2(BANK_DEPTH);
  localparam int RGW        = $clog2(RING);
  localparam int RSW        = $clog2(WINDOW);
  localparam int QCW        = $clog2(QDEPTH + 1);
  localparam int W_RST      = (wmf_pkg::RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : wmf_pkg::RESET_DIM;
  localparam int H_RST      = (wmf_pkg::RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : wmf_pkg::RESET_DIM;

  logic [CW-1:0]  dim_w, dim_w_next;
  logic [RW-1:0]  dim_h, dim_h_next;

  logic [RW-1:0]  in_row, in_row_next, out_row, out_row_next;
  logic [CW-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [RGW-1:0] in_ring, in_ring_next, out_ring, out_ring_next;
  logic [BAW-1:0] in_cq, in_cq_next, out_cq, out_cq_next;
  logic [RSW-1:0] in_cr, in_cr_next, out_cr, out_cr_next;

  logic accept, image_in, drop, wr, job, last;
  logic [RW:0] nr;
  logic [CW:0] nc;
  logic [QCW:0] busy;

  // Stage 1: job position, stage 2: line store read data.
  logic           s1_valid, s1_last;
  logic [RW-1:0]  s1_row;
  logic [CW-1:0]  s1_col;
  logic [RGW-1:0] s1_ring;
  logic [BAW-1:0] s1_cq;
  logic [RSW-1:0] s1_cr;

  logic [WINDOW-1:0] row_ok, col_ok;
  logic [RGW-1:0]    ring_sel [WINDOW];
  logic [RSW-1:0]    res_sel  [WINDOW];
  logic [BAW-1:0]    col_addr [WINDOW];
  logic [BAW-1:0]    baddr    [WINDOW];

  logic              s2_valid, s2_last;
  logic [WINDOW-1:0] s2_row_ok, s2_col_ok;
  logic [RGW-1:0]    s2_ring [WINDOW];
  logic [RSW-1:0]    s2_res  [WINDOW];

  logic [wmf_pkg::PIX_W-1:0] mem [RING][WINDOW][BANK_DEPTH];
  logic [wmf_pkg::PIX_W-1:0] rd  [RING][WINDOW];

  // Configuration: out-of-range sizes are clamped when written.
  always_comb begin
    dim_w_next = dim_w;
    dim_h_next = dim_h;
    if (cfg_data == '0) begin
      dim_w_next = CW'(1);
      dim_h_next = RW'(1);
    end else begin
      dim_w_next = (32'(cfg_data) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(cfg_data);
      dim_h_next = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(cfg_data);
    end
  end

  assign busy     = (QCW+1)'(q_used) + (QCW+1)'(s1_valid) + (QCW+1)'(s2_valid);
  assign s_tready = busy < (QCW+1)'(QDEPTH - 1) + (QCW+1)'(1);
  assign accept   = s_tvalid && s_tready;
  assign image_in = in_row != dim_h;
  assign drop     = image_in && (s_tuser == wmf_pkg::OP_DRAIN);
  assign wr       = accept && image_in && (s_tuser == wmf_pkg::OP_PIXEL);

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    in_ring_next = in_ring;
    in_cq_next   = in_cq;
    in_cr_next   = in_cr;
    out_row_next  = out_row;
    out_col_next  = out_col;
    out_ring_next = out_ring;
    out_cq_next   = out_cq;
    out_cr_next   = out_cr;
    if (wr) begin
      if (in_col + CW'(1) == dim_w) begin
        in_col_next  = '0;
        in_cq_next   = '0;
        in_cr_next   = '0;
        in_row_next  = in_row + RW'(1);
        in_ring_next = (in_ring == RGW'(RING - 1)) ? '0 : in_ring + RGW'(1);
      end else begin
        in_col_next = in_col + CW'(1);
        if (in_cr == RSW'(WINDOW - 1)) begin
          in_cr_next = '0;
          in_cq_next = in_cq + BAW'(1);
        end else begin
          in_cr_next = in_cr + RSW'(1);
        end
      end
    end

    // An output is ready once the bottom-right pixel of its window is in.
    nr = (RW+1)'(out_row) + (RW+1)'(HALF);
    if (nr > (RW+1)'(dim_h - RW'(1))) nr = (RW+1)'(dim_h - RW'(1));
    nc = (CW+1)'(out_col) + (CW+1)'(HALF);
    if (nc > (CW+1)'(dim_w - CW'(1))) nc = (CW+1)'(dim_w - CW'(1));
    job  = accept && !drop &&
           ((nr < (RW+1)'(in_row_next)) ||
            ((nr == (RW+1)'(in_row_next)) && (nc < (CW+1)'(in_col_next))));
    last = (out_row == dim_h - RW'(1)) && (out_col == dim_w - CW'(1));

    if (job) begin
      if (last) begin
        in_row_next   = '0;
        in_col_next   = '0;
        in_ring_next  = '0;
        in_cq_next    = '0;
        in_cr_next    = '0;
        out_row_next  = '0;
        out_col_next  = '0;
        out_ring_next = '0;
        out_cq_next   = '0;
        out_cr_next   = '0;
      end else if (out_col + CW'(1) == dim_w) begin
        out_col_next  = '0;
        out_cq_next   = '0;
        out_cr_next   = '0;
        out_row_next  = out_row + RW'(1);
        out_ring_next = (out_ring == RGW'(RING - 1)) ? '0 : out_ring + RGW'(1);
      end else begin
        out_col_next = out_col + CW'(1);
        if (out_cr == RSW'(WINDOW - 1)) begin
          out_cr_next = '0;
          out_cq_next = out_cq + BAW'(1);
        end else begin
          out_cr_next = out_cr + RSW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_w    <= CW'(W_RST);
      dim_h    <= RW'(H_RST);
      in_row   <= '0;
      in_col   <= '0;
      in_ring  <= '0;
      in_cq    <= '0;
      in_cr    <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_ring <= '0;
      out_cq   <= '0;
      out_cr   <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wmf_pkg::REG_WIDTH:  dim_w <= dim_w_next;
        wmf_pkg::REG_HEIGHT: dim_h <= dim_h_next;
      endcase
      in_row   <= '0;
      in_col   <= '0;
      in_ring  <= '0;
      in_cq    <= '0;
      in_cr    <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_ring <= '0;
      out_cq   <= '0;
      out_cr   <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      in_row   <= in_row_next;
      in_col   <= in_col_next;
      in_ring  <= in_ring_next;
      in_cq    <= in_cq_next;
      in_cr    <= in_cr_next;
      out_row  <= out_row_next;
      out_col  <= out_col_next;
      out_ring <= out_ring_next;
      out_cq   <= out_cq_next;
      out_cr   <= out_cr_next;
      s1_valid <= job;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job) begin
      s1_row  <= out_row;
      s1_col  <= out_col;
      s1_ring <= out_ring;
      s1_cq   <= out_cq;
      s1_cr   <= out_cr;
      s1_last <= last;
    end
  end

  // Window geometry: which ring row and column bank each window slot uses.
  always_comb begin
    int t;
    for (int a = 0; a < WINDOW; a++) begin
      if (a >= HALF) begin
        row_ok[a] = ((RW+1)'(s1_row) + (RW+1)'(a - HALF)) < (RW+1)'(dim_h);
        col_ok[a] = ((CW+1)'(s1_col) + (CW+1)'(a - HALF)) < (CW+1)'(dim_w);
      end else begin
        row_ok[a] = s1_row >= RW'(HALF - a);
        col_ok[a] = s1_col >= CW'(HALF - a);
      end
      t = int'(s1_ring) + a - HALF;
      if (t < 0) t = t + RING;
      else if (t >= RING) t = t - RING;
      ring_sel[a] = RGW'(t);
      t = int'(s1_cr) + a - HALF;
      if (t < 0) begin
        res_sel[a]  = RSW'(t + WINDOW);
        col_addr[a] = s1_cq - BAW'(1);
      end else if (t >= WINDOW) begin
        res_sel[a]  = RSW'(t - WINDOW);
        col_addr[a] = s1_cq + BAW'(1);
      end else begin
        res_sel[a]  = RSW'(t);
        col_addr[a] = s1_cq;
      end
    end
    // Consecutive columns land in distinct banks, so each bank has one address.
    for (int j = 0; j < WINDOW; j++) begin
      baddr[j] = '0;
      for (int b = 0; b < WINDOW; b++) begin
        if (res_sel[b] == RSW'(j)) baddr[j] = col_addr[b];
      end
    end
  end

  // Line store: one bank per ring row and column residue. Reads return the
  // value held before a write in the same cycle.
  always_ff @(posedge clk) begin
    for (int k = 0; k < RING; k++) begin
      for (int j = 0; j < WINDOW; j++) begin
        if (wr && in_ring == RGW'(k) && in_cr == RSW'(j)) begin
          mem[k][j][in_cq] <= s_tdata;
        end
        rd[k][j] <= mem[k][j][baddr[j]];
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_last   <= s1_last;
    s2_row_ok <= row_ok;
    s2_col_ok <= col_ok;
    for (int a = 0; a < WINDOW; a++) begin
      s2_ring[a] <= ring_sel[a];
      s2_res[a]  <= res_sel[a];
    end
  end

  always_comb begin
    for (int a = 0; a < WINDOW; a++) begin
      for (int b = 0; b < WINDOW; b++) begin
        push_data[(a*WINDOW+b)*wmf_pkg::PIX_W +: wmf_pkg::PIX_W] = rd[s2_ring[a]][s2_res[b]];
        push_mask[a*WINDOW+b] = s2_row_ok[a] && s2_col_ok[b];
      end
    end
  end

  assign push      = s2_valid;
  assign push_last = s2_last;

  `WMF_CHECK_NEXT(a_drain_early, clk, rst, accept && drop && !cfg_we, !s1_valid, "drain before image end made an output")
  `WMF_CHECK(a_stall_cause, clk, rst, !s_tready, (q_used != '0) || s1_valid || s2_valid, "input stalled with nothing in flight")

endmodule

// ===== rtl/wmf_queue.sv =====
// ----------------------------------------------------------------------------
// wmf_queue
// Short queue of gathered windows between the front and the back.
// ----------------------------------------------------------------------------
`include "window_median_filter_assert.svh"

module wmf_queue #(
  parameter int DEPTH = wmf_pkg::QUEUE_DEPTH,
  parameter int DW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [DW-1:0]              push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output logic [DW-1:0]              head_data,
  output logic [$clog2(DEPTH+1)-1:0] used
);

  localparam int PW = $clog2(DEPTH);

  logic [DW-1:0] entry [DEPTH];
  logic [PW-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (push && !pop)      used <= used + 1'b1;
      else if (pop && !push) used <= used - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wptr] <= push_data;
  end

  assign head_valid = used != '0;
  assign head_data  = entry[rptr];

  `WMF_CHECK(a_no_overflow, clk, rst, used == ($clog2(DEPTH+1))'(DEPTH), !push || pop, "queue overflow")

endmodule

// ===== rtl/wmf_back.sv =====
// ----------------------------------------------------------------------------
// wmf_back
// Rank-based median of a masked window, three stages to the output register.
// ----------------------------------------------------------------------------
`include "window_median_filter_assert.svh"

module wmf_back #(
  parameter int WINDOW = wmf_pkg::DEF_WINDOW
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         q_valid,
  input  logic [WINDOW*WINDOW*(wmf_pkg::PIX_W+1):0]    q_data,
  output logic                                         q_pop,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [wmf_pkg::PIX_W-1:0]                    m_tdata,
  output logic                                         m_tlast
);

  localparam int NWIN = WINDOW * WINDOW;
  localparam int NW   = $clog2(NWIN + 1);
  localparam int PX   = wmf_pkg::PIX_W;

  logic en;

  logic [NWIN*PX-1:0] in_vals;
  logic [NWIN-1:0]    in_mask;
  logic               in_last;
  logic [NWIN-1:0]    lt [NWIN];
  logic [NW-1:0]      cnt;

  logic               b_valid, b_last;
  logic [NWIN*PX-1:0] b_vals;
  logic [NWIN-1:0]    b_mask;
  logic [NWIN-1:0]    b_lt [NWIN];
  logic [NW-1:0]      b_k;
  logic [NW-1:0]      rank [NWIN];

  logic               c_valid, c_last;
  logic [NWIN*PX-1:0] c_vals;
  logic [NWIN-1:0]    c_mask;
  logic [NW-1:0]      c_rank [NWIN];
  logic [NW-1:0]      c_k;
  logic [NWIN-1:0]    sel;
  logic [PX-1:0]      med;

  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && q_valid;
  assign in_vals = q_data[NWIN*PX-1:0];
  assign in_mask = q_data[NWIN*PX +: NWIN];
  assign in_last = q_data[NWIN*(PX+1)];

  // Element i ranks above every valid element that is smaller, or equal and
  // earlier, so each valid element gets a distinct rank.
  always_comb begin
    cnt = '0;
    for (int i = 0; i < NWIN; i++) begin
      cnt = cnt + NW'(in_mask[i]);
      for (int j = 0; j < NWIN; j++) begin
        lt[i][j] = in_mask[j] && (j != i) &&
                   ((in_vals[j*PX +: PX] < in_vals[i*PX +: PX]) ||
                    ((in_vals[j*PX +: PX] == in_vals[i*PX +: PX]) && (j < i)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NWIN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NWIN; j++) rank[i] = rank[i] + NW'(b_lt[i][j]);
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < NWIN; i++) begin
      sel[i] = c_mask[i] && (c_rank[i] == c_k);
      if (sel[i]) med = med | c_vals[i*PX +: PX];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      b_valid  <= q_pop;
      c_valid  <= b_valid;
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_vals <= in_vals;
      b_mask <= in_mask;
      b_last <= in_last;
      b_k    <= cnt >> 1;
      for (int i = 0; i < NWIN; i++) b_lt[i] <= lt[i];
      c_vals <= b_vals;
      c_mask <= b_mask;
      c_last <= b_last;
      c_k    <= b_k;
      for (int i = 0; i < NWIN; i++) c_rank[i] <= rank[i];
      m_tdata <= med;
      m_tlast <= c_last;
    end
  end

  `WMF_CHECK(a_sel_unique, clk, rst, c_valid, $onehot0(sel), "several window elements share the median rank")
  `WMF_CHECK(a_sel_found, clk, rst, c_valid && (|c_mask), $onehot(sel), "no window element has the median rank")

endmodule

// ===== rtl/window_median_filter.sv =====
// ----------------------------------------------------------------------------
// window_median_filter
// Streaming WINDOW x WINDOW median filter for 8-bit grey raster images.
// ----------------------------------------------------------------------------
// The filter takes one item per clock and keeps that rate as long as the
// output side takes results. Each output is the median of the in-image
// pixels of the window centred on its position (upper median when the count
// is even). The whole window is read at once from a line store of
// (WINDOW+1) x WINDOW banks, one per ring row and column residue; a
// four-entry queue lets the input run while the output stalls, and the
// input stalls once the queue entries plus the windows in the read stages
// reach the queue depth. After the last pixel, drain items flush the
// remaining outputs. Write the size registers only while the filter is idle;
// any write restarts the image.

module window_median_filter #(
  parameter int WINDOW     = wmf_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [wmf_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel
  input  logic                          s_tuser,   // [0] opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [wmf_pkg::PIX_W-1:0]     m_tdata,   // [7:0] median
  output logic                          m_tlast
);

  localparam int NWIN = WINDOW * WINDOW;
  localparam int DW   = NWIN * (wmf_pkg::PIX_W + 1) + 1;
  localparam int QCW  = $clog2(wmf_pkg::QUEUE_DEPTH + 1);

  logic                          push, push_last, pop, head_valid;
  logic [NWIN*wmf_pkg::PIX_W-1:0] push_data;
  logic [NWIN-1:0]               push_mask;
  logic [DW-1:0]                 head_data;
  logic [QCW-1:0]                q_used;

  wmf_front #(
    .WINDOW     (WINDOW),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .QDEPTH     (wmf_pkg::QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_used    (q_used),
    .push      (push),
    .push_data (push_data),
    .push_mask (push_mask),
    .push_last (push_last)
  );

  wmf_queue #(
    .DEPTH (wmf_pkg::QUEUE_DEPTH),
    .DW    (DW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_last, push_mask, push_data}),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .used       (q_used)
  );

  wmf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (head_valid),
    .q_data   (head_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/window_median_filter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_median_filter_test
// Streams small and edge-sized grey images through the 3x3 median filter.
// A local model predicts the median and end-of-image flag for every result,
// and each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module window_median_filter_test;

  localparam int PIX_W     = wmf_pkg::PIX_W;
  localparam int CFG_W     = wmf_pkg::CFG_W;
  localparam int CFG_IDX_W = wmf_pkg::CFG_IDX_W;
  localparam int HALF_WIN  = wmf_pkg::DEF_WINDOW / 2;
  localparam int RING      = wmf_pkg::DEF_WINDOW + 1;
  localparam int SETTLE    = 12;
  localparam int STALL_MAX = 5000;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             last;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [PIX_W-1:0] s_tdata = '0;   // [7:0] pixel
  logic s_tuser = 1'b0;             // [0] opcode
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [PIX_W-1:0] m_tdata;        // [7:0] median
  logic m_tlast;

  window_median_filter dut (.*);

  always #2 clk = ~clk;

  // Model state.
  logic [PIX_W-1:0] rows [RING][wmf_pkg::DEF_MAX_WIDTH];
  int unsigned img_w_reg = wmf_pkg::RESET_DIM, img_h_reg = wmf_pkg::RESET_DIM;
  int unsigned pix_row, pix_col, med_row, med_col;
  filt_result_t pending_medians[$];

  int mismatches = 0;
  int pixel_items = 0;
  int stall_count = 0;
  bit steady = 1'b0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned cur_w();
    return clamp_dim(img_w_reg, wmf_pkg::DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned cur_h();
    return clamp_dim(img_h_reg, wmf_pkg::DEF_MAX_HEIGHT);
  endfunction

  function automatic logic [PIX_W-1:0] window_median_at(int unsigned w, int unsigned h);
    logic [PIX_W-1:0] vals [9];
    logic [PIX_W-1:0] key;
    int n, j;
    int unsigned r0, c0, r1, c1;
    n = 0;
    r0 = (med_row >= HALF_WIN) ? med_row - HALF_WIN : 0;
    c0 = (med_col >= HALF_WIN) ? med_col - HALF_WIN : 0;
    r1 = (med_row + HALF_WIN > h - 1) ? h - 1 : med_row + HALF_WIN;
    c1 = (med_col + HALF_WIN > w - 1) ? w - 1 : med_col + HALF_WIN;
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++) begin
        vals[n] = rows[r % RING][c];
        n++;
      end
    for (int i = 1; i < n; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    return vals[n/2];
  endfunction

  // Advances the model by one accepted item and queues any result.
  function automatic void predict_item(wmf_pkg::opcode_t op, logic [PIX_W-1:0] px);
    int unsigned w, h, nr, nc;
    filt_result_t res;
    w = cur_w();
    h = cur_h();
    if (pix_row < h) begin
      if (op == wmf_pkg::OP_DRAIN) return;
      rows[pix_row % RING][pix_col] = px;
      pix_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        pix_row++;
      end
    end
    nr = (med_row + HALF_WIN > h - 1) ? h - 1 : med_row + HALF_WIN;
    nc = (med_col + HALF_WIN > w - 1) ? w - 1 : med_col + HALF_WIN;
    if (!(nr < pix_row || (nr == pix_row && nc < pix_col))) return;
    res.median = window_median_at(w, h);
    res.last = (med_row == h - 1) && (med_col == w - 1);
    pending_medians.push_back(res);
    if (res.last) begin
      pix_row = 0; pix_col = 0; med_row = 0; med_col = 0;
    end else begin
      med_col++;
      if (med_col >= w) begin
        med_col = 0;
        med_row++;
      end
    end
  endfunction

  task automatic report(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Result checker and output stall generator.
  always @(posedge clk) begin
    filt_result_t want;
    m_tready <= steady || ($urandom_range(99) >= 35);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_medians.size() == 0) begin
        report("unexpected result", m_tdata, '0);
      end else begin
        want = pending_medians.pop_front();
        if (m_tdata !== want.median) report("median", m_tdata, want.median);
        if (m_tlast !== want.last) report("last", PIX_W'(m_tlast), PIX_W'(want.last));
      end
    end
  end

  // Watchdog on cycles where nothing moves.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst ||
        (pending_medians.size() == 0 && !s_tvalid))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(wmf_pkg::opcode_t op, logic [PIX_W-1:0] px);
    while (!steady && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    predict_item(op, px);
    if (op == wmf_pkg::OP_PIXEL) pixel_items++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(wmf_pkg::reg_index_t idx, logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == wmf_pkg::REG_WIDTH) img_w_reg = 32'(value);
    else img_h_reg = 32'(value);
    pix_row = 0; pix_col = 0; med_row = 0; med_col = 0;
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(wmf_pkg::REG_WIDTH, w);
    write_reg(wmf_pkg::REG_HEIGHT, h);
  endtask

  // Sends one image; kind 0 random, 1 all zero, 2 all full scale.
  // With noise, stray drains land mid-image and extra pixels follow it.
  task automatic send_image(int kind, bit noise);
    int unsigned total;
    logic [PIX_W-1:0] px;
    total = cur_w() * cur_h();
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(99) < 8) send_item(wmf_pkg::OP_DRAIN, PIX_W'($urandom));
      px = (kind == 1) ? '0 : (kind == 2) ? '1 : PIX_W'($urandom);
      send_item(wmf_pkg::OP_PIXEL, px);
    end
    while (pix_row == cur_h())
      send_item((noise && $urandom_range(1)) ? wmf_pkg::OP_PIXEL : wmf_pkg::OP_DRAIN,
                PIX_W'($urandom));
  endtask

  task automatic test_small_images();
    set_size(1, 1);
    send_image(2, 0);
    send_image(1, 0);
    set_size(2, 2);
    send_item(wmf_pkg::OP_PIXEL, 8'd10);
    send_item(wmf_pkg::OP_PIXEL, 8'd200);
    send_item(wmf_pkg::OP_PIXEL, 8'd255);
    send_item(wmf_pkg::OP_PIXEL, 8'd0);
    send_image(0, 1);
    set_size(3, 3);
    send_image(0, 0);
  endtask

  // Oversized registers are checked on the first part of a full-size image;
  // the next write restarts the counters.
  task automatic test_register_limits();
    set_size(0, 3);
    send_image(0, 0);
    set_size(2047, 0);
    repeat (40) send_item(wmf_pkg::OP_PIXEL, PIX_W'($urandom));
    set_size(1, 2047);
    repeat (40) send_item(wmf_pkg::OP_PIXEL, PIX_W'($urandom));
  endtask

  task automatic test_unbroken_stream();
    steady = 1'b1;
    set_size(7, 5);
    send_image(0, 0);
    send_image(0, 1);
    steady = 1'b0;
  endtask

  task automatic test_pause_mid_image();
    set_size(6, 6);
    for (int i = 0; i < 20; i++) send_item(wmf_pkg::OP_PIXEL, PIX_W'($urandom));
    wait_drained();
    while (pix_row != 0 || pix_col != 0) send_item(wmf_pkg::OP_PIXEL, PIX_W'($urandom));
    while (pix_row == cur_h()) send_item(wmf_pkg::OP_DRAIN, '0);
    // A write with a partial image in flight restarts the counters.
    for (int i = 0; i < 9; i++) send_item(wmf_pkg::OP_PIXEL, PIX_W'($urandom));
    set_size(4, 3);
    send_image(0, 0);
  endtask

  task automatic test_random_images();
    int target;
    target = pixel_items + 500;
    while (pixel_items < target) begin
      set_size(CFG_W'($urandom_range(1, 9)), CFG_W'($urandom_range(1, 8)));
      repeat ($urandom_range(1, 3)) send_image($urandom_range(9) == 0 ? 2 : 0,
                                               $urandom_range(3) == 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_small_images();
    test_register_limits();
    test_unbroken_stream();
    test_pause_mid_image();
    test_random_images();
    wait_drained();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wmf_pkg.sv
rtl/wmf_front.sv
rtl/wmf_queue.sv
rtl/wmf_back.sv
rtl/window_median_filter.sv
tb/window_median_filter_test.sv
